// ===== src/mstmr_pkg.sv =====
package mstmr_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int SWITCH_MASK_DEF = 3;

	localparam int IN_DATA_W = 72;
	localparam int IN_USER_W = 2;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 2;

	localparam int TIME_W = 32;
	localparam int PERIOD_W = 29;
	localparam int EVT_W = 32;

	// Multiply by this and shift right by DIV10_SHIFT to divide a 32-bit word by ten.
	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int DIV10_SHIFT = 35;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_CONFIG = 2'd1,
		OP_ARM = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_EVENT = 2'd1,
		KIND_TICK = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_CONFIGURED = 2'd1,
		ST_RUNNING = 2'd2
	} status_t;

endpackage

// ===== src/mstmr_ram.sv =====
module mstmr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/multi_slot_software_timer_engine.sv =====
// A configure passes S_CFG_MUL and S_CFG_WR, and an arm S_ARM_RD and S_ARM_WR, before S_REPLY answers; a slot out
// of range goes straight to S_REPLY. A tick with nothing due scans the slots once (S_SCAN_MIN) and then gives its
// tick done; with a due group it also passes S_SCAN_GRP, then S_PICK, S_FIRE and S_FIRE2 for each firing slot.
// Every pass reads the slot memories one entry per cycle through a single shared port, and
// a result that the receiver holds off keeps the sequencer waiting in S_REPLY, S_FIRE2 or S_DONE.
// One item is processed at a time; s_tready is high only while the sequencer is idle.
// arst_n clears the tick counter, the arm sequence and all slot flags; slot memories
// are not cleared, and their contents are used only after they have been written.
module multi_slot_software_timer_engine #(
	parameter int NUM_SLOTS = mstmr_pkg::NUM_SLOTS_DEF,
	parameter int SWITCH_INTERVAL_MASK = mstmr_pkg::SWITCH_MASK_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// slot[3:0], period_ms[35:4], event_data[67:36], has_sink[68], periodic[69]
	input  logic [mstmr_pkg::IN_DATA_W-1:0]     s_tdata,
	// operation[1:0]
	input  logic [mstmr_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// status[1:0], fired_slot[5:2], fired_data[37:6], task_switch[38]
	output logic [mstmr_pkg::OUT_DATA_W-1:0]    m_tdata,
	// kind[1:0]
	output logic [mstmr_pkg::OUT_USER_W-1:0]    m_tuser,
	output logic                                m_tlast
);

	import mstmr_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_CFG_MUL  = 12'b0000_0000_0010,
		S_CFG_WR   = 12'b0000_0000_0100,
		S_ARM_RD   = 12'b0000_0000_1000,
		S_ARM_WR   = 12'b0000_0001_0000,
		S_REPLY    = 12'b0000_0010_0000,
		S_SCAN_MIN = 12'b0000_0100_0000,
		S_SCAN_GRP = 12'b0000_1000_0000,
		S_PICK     = 12'b0001_0000_0000,
		S_FIRE     = 12'b0010_0000_0000,
		S_FIRE2    = 12'b0100_0000_0000,
		S_DONE     = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	logic [TIME_W-1:0]   tick_q;
	logic [TIME_W-1:0]   seq_q;
	logic [NUM_SLOTS-1:0] conf_q, run_q, per_q, sink_q, grp_q;

	logic [3:0]          slot_q;
	logic [31:0]         ms_q;
	logic [EVT_W-1:0]    data_q;
	logic                sink_in_q, per_in_q;
	logic [PERIOD_W-1:0] period_q;
	status_t             st_q;

	logic [CW-1:0]       idx_q;
	logic [SW-1:0]       rd_idx_s1;
	logic                rd_vld_s1;
	logic [TIME_W-1:0]   best_q;
	logic                any_q;
	logic [SW-1:0]       win_q;
	logic [TIME_W-1:0]   win_age_q;
	logic                win_any_q;

	logic                m_tvalid_q, m_tlast_q;
	kind_t               kind_q;
	status_t             ostat_q;
	logic [3:0]          oslot_q;
	logic [EVT_W-1:0]    odata_q;
	logic                osw_q;

	logic [SW-1:0]       raddr, arm_addr, in_addr, slot_a;
	logic [TIME_W-1:0]   tmo_rd, order_rd, age, best_n, tmo_wdata;
	logic [PERIOD_W-1:0] period_rd;
	logic [EVT_W-1:0]    data_rd;
	logic [63:0]         prod;
	logic                out_free, fire_go, arm_wr, cfg_wr;
	logic                cand_min, any_n, cand_pk, win_any_n, scan_last, issue;
	logic                in_range;
	logic [7:0]          sw_mask;

	assign sw_mask = 8'(SWITCH_INTERVAL_MASK);
	assign in_addr = SW'(s_tdata[3:0]);
	assign slot_a = SW'(slot_q);
	assign in_range = {28'd0, s_tdata[3:0]} < 32'(NUM_SLOTS);
	assign prod = ms_q * DIV10_RECIP;

	assign out_free = !m_tvalid_q || m_tready;
	assign fire_go = (state_q == S_FIRE2) && (!sink_q[win_q] || out_free);
	assign arm_wr = (state_q == S_ARM_WR) || (fire_go && per_q[win_q]);
	assign cfg_wr = (state_q == S_CFG_WR);
	assign arm_addr = (state_q == S_ARM_WR) ? slot_a : win_q;
	assign tmo_wdata = {{(TIME_W - PERIOD_W){1'b0}}, period_rd} + tick_q;

	assign issue = ((state_q == S_SCAN_MIN) || (state_q == S_SCAN_GRP) ||
		(state_q == S_PICK)) && (idx_q < CW'(NUM_SLOTS));
	assign scan_last = rd_vld_s1 && (rd_idx_s1 == SW'(NUM_SLOTS - 1));

	assign cand_min = rd_vld_s1 && run_q[rd_idx_s1] && (!any_q || (tmo_rd < best_q));
	assign best_n = cand_min ? tmo_rd : best_q;
	assign any_n = any_q || cand_min;

	assign age = seq_q - order_rd;
	assign cand_pk = rd_vld_s1 && grp_q[rd_idx_s1] && (!win_any_q || (age > win_age_q));
	assign win_any_n = win_any_q || cand_pk;

	always_comb begin
		case (state_q)
			S_ARM_RD, S_ARM_WR: raddr = slot_a;
			S_FIRE, S_FIRE2:    raddr = win_q;
			default:            raddr = idx_q[SW-1:0];
		endcase
	end

	mstmr_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_timeout (
		.clk(clk), .we(arm_wr), .waddr(arm_addr), .wdata(tmo_wdata),
		.raddr(raddr), .rdata(tmo_rd)
	);

	mstmr_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_order (
		.clk(clk), .we(arm_wr), .waddr(arm_addr), .wdata(seq_q),
		.raddr(raddr), .rdata(order_rd)
	);

	mstmr_ram #(.WIDTH(PERIOD_W), .DEPTH(NUM_SLOTS)) u_period (
		.clk(clk), .we(cfg_wr), .waddr(slot_a), .wdata(period_q),
		.raddr(raddr), .rdata(period_rd)
	);

	mstmr_ram #(.WIDTH(EVT_W), .DEPTH(NUM_SLOTS)) u_data (
		.clk(clk), .we(cfg_wr), .waddr(slot_a), .wdata(data_q),
		.raddr(raddr), .rdata(data_rd)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			slot_q <= s_tdata[3:0];
			ms_q <= s_tdata[35:4];
			data_q <= s_tdata[67:36];
			sink_in_q <= s_tdata[68];
			per_in_q <= s_tdata[69];
		end
		if (state_q == S_CFG_MUL) begin
			period_q <= PERIOD_W'(prod >> DIV10_SHIFT);
		end
		rd_idx_s1 <= idx_q[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tick_q <= '0;
			seq_q <= '0;
			conf_q <= '0;
			run_q <= '0;
			per_q <= '0;
			sink_q <= '0;
			grp_q <= '0;
			st_q <= ST_OK;
			idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			best_q <= '0;
			any_q <= 1'b0;
			win_q <= '0;
			win_age_q <= '0;
			win_any_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tlast_q <= 1'b0;
			kind_q <= KIND_STATUS;
			ostat_q <= ST_OK;
			oslot_q <= '0;
			odata_q <= '0;
			osw_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						case (op_t'(s_tuser))
							OP_TICK: begin
								tick_q <= tick_q + TIME_W'(1);
								idx_q <= '0;
								any_q <= 1'b0;
								state_q <= S_SCAN_MIN;
							end
							OP_CONFIG: begin
								if (in_range) begin
									state_q <= S_CFG_MUL;
								end else begin
									st_q <= ST_NOT_CONFIGURED;
									state_q <= S_REPLY;
								end
							end
							OP_ARM: begin
								if (!in_range) begin
									st_q <= ST_NOT_CONFIGURED;
									state_q <= S_REPLY;
								end else if (!conf_q[in_addr]) begin
									st_q <= ST_NOT_CONFIGURED;
									state_q <= S_REPLY;
								end else if (run_q[in_addr]) begin
									st_q <= ST_RUNNING;
									state_q <= S_REPLY;
								end else begin
									state_q <= S_ARM_RD;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CFG_MUL: begin
					state_q <= S_CFG_WR;
				end
				S_CFG_WR: begin
					conf_q[slot_a] <= 1'b1;
					per_q[slot_a] <= per_in_q;
					sink_q[slot_a] <= sink_in_q;
					st_q <= ST_OK;
					state_q <= S_REPLY;
				end
				S_ARM_RD: begin
					state_q <= S_ARM_WR;
				end
				S_ARM_WR: begin
					run_q[slot_a] <= 1'b1;
					seq_q <= seq_q + TIME_W'(1);
					st_q <= ST_OK;
					state_q <= S_REPLY;
				end
				S_REPLY: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tlast_q <= 1'b1;
						kind_q <= KIND_STATUS;
						ostat_q <= st_q;
						oslot_q <= '0;
						odata_q <= '0;
						osw_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_SCAN_MIN: begin
					best_q <= best_n;
					any_q <= any_n;
					if (scan_last) begin
						idx_q <= '0;
						grp_q <= '0;
						if (any_n && (best_n <= tick_q)) begin
							state_q <= S_SCAN_GRP;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN_GRP: begin
					if (rd_vld_s1 && run_q[rd_idx_s1] && (tmo_rd == best_q)) begin
						grp_q[rd_idx_s1] <= 1'b1;
					end
					if (scan_last) begin
						idx_q <= '0;
						win_any_q <= 1'b0;
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (cand_pk) begin
						win_q <= rd_idx_s1;
						win_age_q <= age;
					end
					win_any_q <= win_any_n;
					if (scan_last) begin
						state_q <= win_any_n ? S_FIRE : S_DONE;
					end
				end
				S_FIRE: begin
					state_q <= S_FIRE2;
				end
				S_FIRE2: begin
					if (fire_go) begin
						grp_q[win_q] <= 1'b0;
						run_q[win_q] <= per_q[win_q];
						if (per_q[win_q]) begin
							seq_q <= seq_q + TIME_W'(1);
						end
						if (sink_q[win_q]) begin
							m_tvalid_q <= 1'b1;
							m_tlast_q <= 1'b0;
							kind_q <= KIND_EVENT;
							ostat_q <= ST_OK;
							oslot_q <= 4'(win_q);
							odata_q <= data_rd;
							osw_q <= 1'b0;
						end
						idx_q <= '0;
						win_any_q <= 1'b0;
						state_q <= S_PICK;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tlast_q <= 1'b1;
						kind_q <= KIND_TICK;
						ostat_q <= ST_OK;
						oslot_q <= '0;
						odata_q <= '0;
						osw_q <= ((tick_q[7:0] & sw_mask) == 8'd0);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tlast = m_tlast_q;
	assign m_tuser = kind_q;
	assign m_tdata = {1'b0, osw_q, odata_q, oslot_q, ostat_q};

endmodule
